### hdl/cbm_pkg.sv
package cbm_pkg;

    localparam logic [1:0] FUNC_CPU_RD = 2'd0;
    localparam logic [1:0] FUNC_CPU_WR = 2'd1;
    localparam logic [1:0] FUNC_PPU_RD = 2'd2;

    localparam logic [2:0] TGT_OPEN = 3'd0;
    localparam logic [2:0] TGT_PRG  = 3'd1;
    localparam logic [2:0] TGT_RAM  = 3'd2;
    localparam logic [2:0] TGT_CHR  = 3'd3;
    localparam logic [2:0] TGT_NT   = 3'd4;

    localparam logic [1:0] CFG_VARIANT  = 2'd0;
    localparam logic [1:0] CFG_PRG_MASK = 2'd1;
    localparam logic [1:0] CFG_CHR_MASK = 2'd2;

    localparam logic [11:0] REG_PAGE  = 12'h7EF;
    localparam logic [7:0]  RAM_PAGE  = 8'h7F;
    localparam logic [3:0]  REG_MIRROR = 4'h6;
    localparam logic [3:0]  REG_PRG0_A = 4'hA;
    localparam logic [3:0]  REG_PRG0_B = 4'hB;
    localparam logic [3:0]  REG_PRG1_A = 4'hC;
    localparam logic [3:0]  REG_PRG1_B = 4'hD;
    localparam logic [3:0]  REG_PRG2_A = 4'hE;
    localparam logic [3:0]  REG_PRG2_B = 4'hF;
    localparam logic [3:0]  REG_CHR_LAST = 4'h5;

    localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;
    localparam logic [7:0] PRG0_RESET = 8'h00;
    localparam logic [7:0] PRG1_RESET = 8'h01;
    localparam logic [7:0] PRG2_RESET = 8'hFE;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  target;
        logic [20:0] rom_address;
        logic [10:0] nametable_address;
        logic [7:0]  read_data;
    } t_out_item;

endpackage

### hdl/cbm_ram.sv
module cbm_ram #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);

    // Entries that were never written read as zero through their valid bits.
    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rdata;
    logic [DEPTH-1:0] r_valid;
    logic             r_valid_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_valid_q <= 1'b0;
        end else begin
            if (i_en) begin
                r_valid_q <= r_valid[i_addr];
            end
            if (i_en && i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_valid_q ? r_rdata : 8'd0;

endmodule

### hdl/cartridge_bank_mapper.sv
// Cartridge bank mapper: translates one CPU or PPU bus access per item.
// The input channel carries the access kind, the address and the write byte.
// The output channel returns the target, the banked ROM address, the
// nametable address and, for CPU reads of 0x7F00-0x7FFF, the RAM byte.
// Items are registered at the edge that accepts them; without stalls a new
// item can be accepted in every cycle, so throughput is one item per cycle.
// The internal RAM is a single-port synchronous memory with a registered read;
// a write in one cycle is seen by a read in the next, so no interlock exists.
// Bank registers are updated at the edge that accepts a register write.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle; the block does not enforce it. Reset restores
// the default bank registers and masks, and clears one valid bit per RAM entry
// at once, so the RAM reads as zero after reset. When the receiver stalls, the
// output register holds its item and input is accepted only once it has left.
module cartridge_bank_mapper #(
    parameter int RAM_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbm_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_wdata
);

    localparam int IDX_W = $clog2(RAM_DEPTH);

    logic       r_variant;
    logic [7:0] r_prg_mask;
    logic [7:0] r_chr_mask;
    logic [7:0] r_prg_bank [3];
    logic [7:0] r_chr_bank [6];
    logic       r_mirror_v;

    logic               r_out_valid;
    cbm_pkg::t_out_item r_out;
    logic               r_ram_read;

    logic               accept;
    logic               reg_wr;
    logic               ram_hit;
    logic               ram_we;
    logic [7:0]         ram_rdata;
    logic [13:0]        pa;
    logic [7:0]         prg_bank;
    logic [7:0]         chr_bank;
    logic               page;
    cbm_pkg::t_out_item n_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign reg_wr  = (i_in_item.func == cbm_pkg::FUNC_CPU_WR)
                     && (i_in_item.address[15:4] == cbm_pkg::REG_PAGE);
    assign ram_hit = ((i_in_item.func == cbm_pkg::FUNC_CPU_RD)
                      || (i_in_item.func == cbm_pkg::FUNC_CPU_WR))
                     && (i_in_item.address[15:8] == cbm_pkg::RAM_PAGE);
    assign ram_we  = ram_hit && (i_in_item.func == cbm_pkg::FUNC_CPU_WR);
    assign pa      = i_in_item.address[13:0];

    always_comb begin
        if (i_in_item.address[14:13] == 2'd3) begin
            prg_bank = cbm_pkg::PRG_FIXED_BANK;
        end else begin
            prg_bank = r_prg_bank[i_in_item.address[14:13]];
        end
        prg_bank = prg_bank & r_prg_mask;

        if (!pa[12]) begin
            chr_bank = {r_chr_bank[{2'b00, pa[11]}][7:1], pa[10]};
        end else begin
            chr_bank = r_chr_bank[3'd2 + {1'b0, pa[11:10]}];
        end
        chr_bank = chr_bank & r_chr_mask;

        if (r_variant) begin
            page = r_chr_bank[{2'b00, pa[11]}][7];
        end else if (r_mirror_v) begin
            page = pa[10];
        end else begin
            page = pa[11];
        end

        n_out = '0;
        unique case (i_in_item.func)
            cbm_pkg::FUNC_CPU_RD, cbm_pkg::FUNC_CPU_WR: begin
                if (i_in_item.address[15]) begin
                    n_out.target      = cbm_pkg::TGT_PRG;
                    n_out.rom_address = {prg_bank, i_in_item.address[12:0]};
                end else if (ram_hit) begin
                    n_out.target = cbm_pkg::TGT_RAM;
                end
            end
            cbm_pkg::FUNC_PPU_RD: begin
                if (!pa[13]) begin
                    n_out.target      = cbm_pkg::TGT_CHR;
                    n_out.rom_address = {3'd0, chr_bank, pa[9:0]};
                end else begin
                    n_out.target            = cbm_pkg::TGT_NT;
                    n_out.nametable_address = {page, pa[9:0]};
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    cbm_ram #(
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_we    (ram_we),
        .i_addr  (i_in_item.address[IDX_W-1:0]),
        .i_wdata (i_in_item.write_data),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant     <= 1'b0;
            r_prg_mask    <= 8'hFF;
            r_chr_mask    <= 8'hFF;
            r_prg_bank[0] <= cbm_pkg::PRG0_RESET;
            r_prg_bank[1] <= cbm_pkg::PRG1_RESET;
            r_prg_bank[2] <= cbm_pkg::PRG2_RESET;
            for (int i = 0; i < 6; i++) begin
                r_chr_bank[i] <= 8'd0;
            end
            r_mirror_v    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ram_read    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cbm_pkg::CFG_VARIANT:  r_variant  <= i_cfg_wdata[0];
                    cbm_pkg::CFG_PRG_MASK: r_prg_mask <= i_cfg_wdata;
                    cbm_pkg::CFG_CHR_MASK: r_chr_mask <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept && reg_wr) begin
                priority if (i_in_item.address[3:0] <= cbm_pkg::REG_CHR_LAST) begin
                    r_chr_bank[i_in_item.address[2:0]] <= i_in_item.write_data;
                end else if (i_in_item.address[3:0] == cbm_pkg::REG_MIRROR) begin
                    r_mirror_v <= i_in_item.write_data[0];
                end else if (i_in_item.address[3:0] == cbm_pkg::REG_PRG0_A
                             || i_in_item.address[3:0] == cbm_pkg::REG_PRG0_B) begin
                    r_prg_bank[0] <= i_in_item.write_data;
                end else if (i_in_item.address[3:0] == cbm_pkg::REG_PRG1_A
                             || i_in_item.address[3:0] == cbm_pkg::REG_PRG1_B) begin
                    r_prg_bank[1] <= i_in_item.write_data;
                end else if (i_in_item.address[3:0] == cbm_pkg::REG_PRG2_A
                             || i_in_item.address[3:0] == cbm_pkg::REG_PRG2_B) begin
                    r_prg_bank[2] <= i_in_item.write_data;
                end else begin
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_ram_read  <= ram_hit && !ram_we;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid                  = r_out_valid;
    assign o_out_item.target            = r_out.target;
    assign o_out_item.rom_address       = r_out.rom_address;
    assign o_out_item.nametable_address = r_out.nametable_address;
    assign o_out_item.read_data         = r_ram_read ? ram_rdata : 8'd0;

endmodule
